FILE: sv/sha_pkg.sv
package sha_pkg;

	// Request carried on the input channel
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} sha_in_t;

	// Request carried on the output channel
	typedef struct packed {
		logic [31:0] digest_word;
		logic        last_word;
	} sha_out_t;

	// Queue entry kinds between front and back
	typedef enum logic {
		Q_WORD   = 1'b0,
		Q_FINISH = 1'b1
	} qkind_t;

	// A full big-endian word, or the message tail (0..4 bytes, right-aligned)
	typedef struct packed {
		qkind_t      kind;
		logic [2:0]  nbytes;
		logic [31:0] data;
	} qentry_t;

	localparam int QAddrW = 2;
	localparam int QDepth = 1 << QAddrW;

	localparam logic [7:0]  PadMark  = 8'h80;
	localparam logic [31:0] PadWord  = {PadMark, 24'h000000};
	localparam logic [2:0]  FullWord = 3'd4;

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

FILE: sv/sha_front.sv
module sha_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sha_pkg::sha_in_t in_data,
	output logic             push_valid,
	input  logic             push_ready,
	output sha_pkg::qentry_t push_entry
);
	import sha_pkg::*;

	logic [23:0] part_q;   // pending bytes, newest in the low byte
	logic [1:0]  idx_q;    // number of pending bytes
	logic [31:0] merged;
	logic        accept;

	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;
	assign merged   = {part_q, in_data.data_byte};

	// Classify: full word, message tail, or nothing
	always_comb begin
		push_valid        = 1'b0;
		push_entry.kind   = Q_WORD;
		push_entry.nbytes = FullWord;
		push_entry.data   = merged;
		if (in_data.end_of_message) begin
			push_valid      = in_valid;
			push_entry.kind = Q_FINISH;
			if (in_data.byte_present) begin
				push_entry.nbytes = {1'b0, idx_q} + 3'd1;
			end else begin
				push_entry.nbytes = {1'b0, idx_q};
				push_entry.data   = {8'h00, part_q};
			end
		end else if (in_data.byte_present && idx_q == 2'd3) begin
			push_valid = in_valid;
		end
	end

	// Byte packing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (accept) begin
			if (in_data.end_of_message) begin
				idx_q <= 2'd0;
			end else if (in_data.byte_present) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_data.byte_present) begin
			part_q <= merged[23:0];
		end
	end

endmodule

FILE: sv/sha_fifo.sv
module sha_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  sha_pkg::qentry_t push_entry,
	output logic             pop_valid,
	input  logic             pop_ready,
	output sha_pkg::qentry_t pop_entry
);
	import sha_pkg::*;

	qentry_t            mem_q [QDepth];
	logic [QAddrW-1:0]  wptr_q;
	logic [QAddrW-1:0]  rptr_q;
	logic [QAddrW:0]    count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = count_q != (QAddrW + 1)'(QDepth);
	assign pop_valid  = count_q != '0;
	assign pop_entry  = mem_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + 1'b1;
			if (do_pop)  rptr_q <= rptr_q + 1'b1;
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

endmodule

FILE: sv/sha_core.sv
module sha_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  sha_pkg::qentry_t  q_entry,
	output logic              out_valid,
	input  logic              out_ready,
	output sha_pkg::sha_out_t out_data
);
	import sha_pkg::*;

	typedef enum logic [4:0] {
		ST_LOAD  = 5'b00001,
		ST_PAD   = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_SUM   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t       state_q;
	logic [31:0]  win_q   [16];  // schedule window, oldest word at index 0
	logic [31:0]  chain_q [8];
	logic [31:0]  wv_q    [8];   // working variables a..h
	logic [3:0]   cnt_q;         // words in the current block
	logic [5:0]   rnd_q;
	logic [2:0]   oidx_q;
	logic [60:0]  bcount_q;
	logic         fin_q;         // message end seen, padding in progress
	logic         mark_q;        // pad mark still to place
	logic         lenhi_q;       // length words placed in this block

	logic         pop;
	logic         push_en;
	logic [31:0]  push_word;
	logic [31:0]  w_next;
	logic [31:0]  t1;
	logic [31:0]  t2;
	logic [31:0]  ch;
	logic [31:0]  mj;
	logic [31:0]  len_hi;
	logic [31:0]  len_lo;

	assign q_ready = state_q == ST_LOAD;
	assign pop     = q_valid && q_ready;
	assign len_hi  = bcount_q[60:29];
	assign len_lo  = {bcount_q[28:0], 3'b000};

	// Word entering the window: message data, tail with mark, pad or length
	always_comb begin
		push_en   = 1'b0;
		push_word = '0;
		if (pop) begin
			push_en = 1'b1;
			if (q_entry.kind == Q_WORD) begin
				push_word = q_entry.data;
			end else begin
				unique case (q_entry.nbytes)
					3'd0:    push_word = PadWord;
					3'd1:    push_word = {q_entry.data[7:0], PadMark, 16'h0000};
					3'd2:    push_word = {q_entry.data[15:0], PadMark, 8'h00};
					3'd3:    push_word = {q_entry.data[23:0], PadMark};
					default: push_word = q_entry.data;
				endcase
			end
		end else if (state_q == ST_PAD) begin
			push_en = 1'b1;
			if (mark_q) begin
				push_word = PadWord;
			end else if (cnt_q == 4'd14) begin
				push_word = len_hi;
			end else if (cnt_q == 4'd15 && lenhi_q) begin
				push_word = len_lo;
			end
		end
	end

	// Round logic
	always_comb begin
		w_next = small_s1(win_q[14]) + win_q[9] + small_s0(win_q[1]) + win_q[0];
		ch     = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
		mj     = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
		t1     = wv_q[7] + big_s1(wv_q[4]) + ch + RoundK[rnd_q] + win_q[0];
		t2     = big_s0(wv_q[0]) + mj;
	end

	// Sequencer and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			cnt_q    <= '0;
			rnd_q    <= '0;
			oidx_q   <= '0;
			bcount_q <= '0;
			fin_q    <= 1'b0;
			mark_q   <= 1'b0;
			lenhi_q  <= 1'b0;
			for (int i = 0; i < 8; i++) chain_q[i] <= InitHash[i];
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (pop) begin
						cnt_q <= cnt_q + 4'd1;
						if (q_entry.kind == Q_WORD) begin
							bcount_q <= bcount_q + 61'd4;
						end else begin
							bcount_q <= bcount_q + 61'(q_entry.nbytes);
							fin_q    <= 1'b1;
							mark_q   <= q_entry.nbytes == FullWord;
						end
						if (cnt_q == 4'd15) begin
							state_q <= ST_ROUND;
							rnd_q   <= '0;
						end else if (q_entry.kind == Q_FINISH) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					cnt_q  <= cnt_q + 4'd1;
					mark_q <= 1'b0;
					if (!mark_q && cnt_q == 4'd14) lenhi_q <= 1'b1;
					if (cnt_q == 4'd15) begin
						state_q <= ST_ROUND;
						rnd_q   <= '0;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_SUM;
				end
				ST_SUM: begin
					for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + wv_q[i];
					if (fin_q && lenhi_q) begin
						state_q <= ST_OUT;
						oidx_q  <= '0;
					end else if (fin_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) chain_q[i] <= InitHash[i];
							bcount_q <= '0;
							fin_q    <= 1'b0;
							mark_q   <= 1'b0;
							lenhi_q  <= 1'b0;
							state_q  <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// Window and working variables
	always_ff @(posedge clk) begin
		if (push_en) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
			win_q[15] <= push_word;
			if (cnt_q == 4'd15) begin
				for (int i = 0; i < 8; i++) wv_q[i] <= chain_q[i];
			end
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
			win_q[15] <= w_next;
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
	end

	assign out_valid            = state_q == ST_OUT;
	assign out_data.digest_word = chain_q[oidx_q];
	assign out_data.last_word   = oidx_q == 3'd7;

endmodule

FILE: sv/sha256_stream_hasher.sv
// Channel  Signals                          Request
// in       in_valid / in_ready / in_data    one byte, present flag, end flag
// out      out_valid / out_ready / out_data one digest word, last-word flag
//
// The front packs bytes into words, one byte per cycle, into a four-entry queue.
// The back takes one word per cycle while the queue holds entries, then runs 64
// rounds and a chaining-value update per 64-byte block. Message end adds padding
// words, plus one extra block when the length does not fit, then eight digest
// words. Reset clears control state and loads the initial hash; window,
// working variables and queue storage are unreset. The front stalls only when
// the queue is full.
module sha256_stream_hasher (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sha_pkg::sha_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output sha_pkg::sha_out_t out_data
);
	import sha_pkg::*;

	logic    push_valid;
	logic    push_ready;
	qentry_t push_entry;
	logic    q_valid;
	logic    q_ready;
	qentry_t q_entry;

	sha_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	sha_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_entry  (q_entry)
	);

	sha_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_entry   (q_entry),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
